### sv/ces_pkg.sv
// ----------------------------------------------------------------------------
// ces_pkg: shared types and constants for the crop edge scan core
// Field widths, register indexes, reset values and the controller states.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ces_pkg;

  localparam int INT_W    = 8;   // intensity sample
  localparam int BIAS_W   = 16;  // Q8.8 mean bias
  localparam int RATIO_W  = 24;  // Q.16 ratio
  localparam int OFFSET_W = 11;  // reported edge offset
  localparam int MEAN_W   = 16;  // Q8.8 mean, at most 255 * 256
  localparam int FRAC_W   = 16;  // fraction bits of the ratio

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  localparam int DEF_WINDOW_DEPTH    = 16;
  localparam int DEF_MAX_SCAN_LENGTH = 2048;

  localparam logic [CFG_IDX_W-1:0] CFG_BACKGROUND = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BIAS       = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD  = 2'd2;

  localparam logic [INT_W-1:0]   BACKGROUND_RESET = 8'd24;
  localparam logic [BIAS_W-1:0]  BIAS_RESET       = 16'd6554;
  localparam logic [RATIO_W-1:0] THRESHOLD_RESET  = 24'd73662;
  localparam logic [RATIO_W-1:0] RATIO_ONE        = 24'h010000;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_MEAN_DIV,
    ST_RATIO_START,
    ST_RATIO_DIV,
    ST_UPDATE,
    ST_FINISH
  } state_t;

endpackage

### sv/crop_edge_scan_core.sv
// ----------------------------------------------------------------------------
// crop_edge_scan_core: dark border end finder over one half line of samples
// An item that forms a ratio passes through accept, start, both mean divides in
// parallel, a load, the ratio divide, update and finish. Items before the older
// window holds a nonzero sum go from start straight to finish; items after an
// early stop skip the windows and go to finish only when they end the line.
// The result beat is valid the cycle after finish. Synchronous reset, no sweep.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module crop_edge_scan_core
  import ces_pkg::*;
#(
  parameter int WINDOW_DEPTH    = DEF_WINDOW_DEPTH,
  parameter int MAX_SCAN_LENGTH = DEF_MAX_SCAN_LENGTH
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [INT_W-1:0]      intensity,
  input  logic                  last_in_line,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [OFFSET_W-1:0]   edge_offset,
  output logic [RATIO_W-1:0]    best_ratio,
  output logic                  stopped_early
);

  localparam int CNT_W   = $clog2(WINDOW_DEPTH + 1);
  localparam int TOTAL_W = $clog2(WINDOW_DEPTH * ((1 << INT_W) - 1) + 1);
  localparam int MNUM_W  = TOTAL_W + INT_W;
  localparam int RDEN_W  = MEAN_W + 1;
  localparam int RNUM_W  = RDEN_W + FRAC_W;
  localparam int IDX_W   = $clog2(MAX_SCAN_LENGTH);

  state_t state, state_next;

  logic [INT_W-1:0]    background_level;
  logic [BIAS_W-1:0]   mean_bias;
  logic [RATIO_W-1:0]  break_threshold;

  logic                last_flag;
  logic [IDX_W-1:0]    sample_index;
  logic [RATIO_W-1:0]  best_value;
  logic [OFFSET_W-1:0] best_position;
  logic                scan_halted;

  logic accept, push, out_free, line_init;
  logic mean_start, ratio_start;

  logic [INT_W-1:0]   newer_out, older_out;
  logic               newer_full, older_full;
  logic [CNT_W-1:0]   newer_count, older_count;
  logic [TOTAL_W-1:0] newer_total, older_total;
  logic [INT_W-1:0]   newer_seed;

  logic [MNUM_W-1:0]  newer_quot, older_quot;
  logic               mean_done, older_done;
  logic [RNUM_W-1:0]  ratio_num, ratio_quot;
  logic [RDEN_W-1:0]  ratio_den;
  logic               ratio_done;
  logic [RATIO_W-1:0] ratio;
  logic [OFFSET_W-1:0] position;
  logic [IDX_W-1:0]   index_next;

  assign in_ready  = (state == ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign push      = accept && !scan_halted;
  assign out_free  = !out_valid || out_ready;
  assign line_init = (state == ST_FINISH) && last_flag && out_free;
  assign newer_seed = rst ? BACKGROUND_RESET : background_level;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      background_level <= BACKGROUND_RESET;
      mean_bias        <= BIAS_RESET;
      break_threshold  <= THRESHOLD_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_BACKGROUND: background_level <= cfg_data[INT_W-1:0];
        CFG_BIAS:       mean_bias        <= cfg_data[BIAS_W-1:0];
        CFG_THRESHOLD:  break_threshold  <= cfg_data[RATIO_W-1:0];
        default: ;
      endcase
    end
  end

  ces_window #(
    .DEPTH (WINDOW_DEPTH)
  ) u_newer (
    .clk    (clk),
    .rst    (rst),
    .init   (line_init),
    .seeded (1'b1),
    .seed   (newer_seed),
    .push   (push),
    .din    (intensity),
    .dout   (newer_out),
    .full   (newer_full),
    .count  (newer_count),
    .total  (newer_total)
  );

  ces_window #(
    .DEPTH (WINDOW_DEPTH)
  ) u_older (
    .clk    (clk),
    .rst    (rst),
    .init   (line_init),
    .seeded (1'b0),
    .seed   ('0),
    .push   (push && newer_full),
    .din    (newer_out),
    .dout   (older_out),
    .full   (older_full),
    .count  (older_count),
    .total  (older_total)
  );

  ces_sdiv #(
    .NUM_W (MNUM_W),
    .DEN_W (CNT_W)
  ) u_newer_mean (
    .clk   (clk),
    .rst   (rst),
    .start (mean_start),
    .num   ({newer_total, {INT_W{1'b0}}}),
    .den   (newer_count),
    .quot  (newer_quot),
    .done  (mean_done)
  );

  // runs in lockstep with the newer mean divide
  ces_sdiv #(
    .NUM_W (MNUM_W),
    .DEN_W (CNT_W)
  ) u_older_mean (
    .clk   (clk),
    .rst   (rst),
    .start (mean_start),
    .num   ({older_total, {INT_W{1'b0}}}),
    .den   (older_count),
    .quot  (older_quot),
    .done  (older_done)
  );

  assign ratio_num = {RDEN_W'(newer_quot[MEAN_W-1:0]) + RDEN_W'(mean_bias),
                      {FRAC_W{1'b0}}};
  assign ratio_den = RDEN_W'(older_quot[MEAN_W-1:0]) + RDEN_W'(mean_bias);

  ces_sdiv #(
    .NUM_W (RNUM_W),
    .DEN_W (RDEN_W)
  ) u_ratio (
    .clk   (clk),
    .rst   (rst),
    .start (ratio_start),
    .num   (ratio_num),
    .den   (ratio_den),
    .quot  (ratio_quot),
    .done  (ratio_done)
  );

  // saturate the ratio to its field width
  assign ratio = (|ratio_quot[RNUM_W-1:RATIO_W]) ? '1 : ratio_quot[RATIO_W-1:0];
  assign position = OFFSET_W'(sample_index) + OFFSET_W'(1) - OFFSET_W'(newer_count);
  assign index_next = (sample_index == IDX_W'(MAX_SCAN_LENGTH - 1)) ? '0
                    : sample_index + IDX_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    mean_start  = 1'b0;
    ratio_start = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if (!scan_halted) begin
            state_next = ST_START;
          end else if (last_in_line) begin
            state_next = ST_FINISH;
          end
        end
      end
      ST_START: begin
        if (older_total != '0) begin
          mean_start = 1'b1;
          state_next = ST_MEAN_DIV;
        end else begin
          state_next = ST_FINISH;
        end
      end
      ST_MEAN_DIV: begin
        if (mean_done && older_done) begin
          state_next = ST_RATIO_START;
        end
      end
      ST_RATIO_START: begin
        ratio_start = 1'b1;
        state_next  = ST_RATIO_DIV;
      end
      ST_RATIO_DIV: begin
        if (ratio_done) begin
          state_next = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (!last_flag || out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      last_flag <= last_in_line;
    end
  end

  // line scan state
  always_ff @(posedge clk) begin
    if (rst || line_init) begin
      sample_index  <= '0;
      best_value    <= '0;
      best_position <= '0;
      scan_halted   <= 1'b0;
    end else if (state == ST_START && older_total == '0) begin
      sample_index <= index_next;
    end else if (state == ST_UPDATE) begin
      sample_index <= index_next;
      if (best_value < ratio) begin
        best_value    <= ratio;
        best_position <= position;
      end else if (best_value > break_threshold && older_full &&
                   ratio < RATIO_ONE && ratio < best_value) begin
        scan_halted <= 1'b1;
      end
    end
  end

  // result beat register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (line_init) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (line_init) begin
      edge_offset   <= best_position;
      best_ratio    <= best_value;
      stopped_early <= scan_halted;
    end
  end

endmodule

### sv/ces_window.sv
// ----------------------------------------------------------------------------
// ces_window: sliding sample window as a shift line
// Keeps fill count and running sum; the oldest sample sits at the last tap.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ces_window
  import ces_pkg::*;
#(
  parameter int DEPTH   = DEF_WINDOW_DEPTH,
  parameter int CNT_W   = $clog2(DEPTH + 1),
  parameter int TOTAL_W = $clog2(DEPTH * ((1 << INT_W) - 1) + 1)
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               init,
  input  logic               seeded,
  input  logic [INT_W-1:0]   seed,
  input  logic               push,
  input  logic [INT_W-1:0]   din,
  output logic [INT_W-1:0]   dout,
  output logic               full,
  output logic [CNT_W-1:0]   count,
  output logic [TOTAL_W-1:0] total
);

  logic [INT_W-1:0] taps [DEPTH];

  assign dout = taps[DEPTH-1];
  assign full = (count == CNT_W'(DEPTH));

  always_ff @(posedge clk) begin
    if (rst || init) begin
      count <= CNT_W'(seeded);
      total <= seeded ? TOTAL_W'(seed) : '0;
    end else if (push) begin
      if (full) begin
        total <= total - TOTAL_W'(dout) + TOTAL_W'(din);
      end else begin
        count <= count + CNT_W'(1);
        total <= total + TOTAL_W'(din);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || init) begin
      taps[0] <= seed;
    end else if (push) begin
      taps[0] <= din;
      for (int i = 1; i < DEPTH; i++) begin
        taps[i] <= taps[i-1];
      end
    end
  end

endmodule

### sv/ces_sdiv.sv
// ----------------------------------------------------------------------------
// ces_sdiv: bit-serial restoring divider
// One quotient bit per cycle; quotient shifts in behind the numerator bits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ces_sdiv #(
  parameter int NUM_W  = 20,
  parameter int DEN_W  = 5,
  parameter int STEP_W = $clog2(NUM_W)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic [NUM_W-1:0] quot,
  output logic             done
);

  logic              busy;
  logic [STEP_W-1:0] step;
  logic [NUM_W-1:0]  sr;
  logic [DEN_W-1:0]  rem;
  logic [DEN_W-1:0]  dv;
  logic [DEN_W:0]    shifted;
  logic [DEN_W:0]    diff;
  logic              fits;

  assign shifted = {rem, sr[NUM_W-1]};
  assign diff    = shifted - {1'b0, dv};
  assign fits    = (shifted >= {1'b0, dv});
  assign quot    = sr;
  assign done    = busy && (step == STEP_W'(NUM_W - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
    end else if (start) begin
      busy <= 1'b1;
      step <= '0;
    end else if (busy) begin
      step <= step + STEP_W'(1);
      if (done) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      sr  <= num;
      rem <= '0;
      dv  <= den;
    end else if (busy) begin
      sr  <= {sr[NUM_W-2:0], fits};
      rem <= fits ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
    end
  end

endmodule
